@@ rtl/uimp_pkg.sv @@
// Package for the identifier match parser.
// Holds the payload structs, function/status codes and character constants.
// No dependencies.
package uimp_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int IDENT_MAX_DEF  = 24;
  localparam int DATA_MAX_DEF   = 128;

  localparam logic [7:0] CH_START = 8'h2B;  // '+'
  localparam logic [7:0] CH_END   = 8'h3A;  // ':'
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [2:0] FN_MODEM  = 3'd0;
  localparam logic [2:0] FN_SPARE1 = 3'd1;
  localparam logic [2:0] FN_STAGE  = 3'd2;
  localparam logic [2:0] FN_REG    = 3'd3;
  localparam logic [2:0] FN_UNREG  = 3'd4;
  localparam logic [2:0] FN_READ   = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_STG_FULL = 2'd2;
  localparam logic [1:0] ST_NO_READ  = 2'd3;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic [6:0] read_index;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       notify;
    logic [2:0] notify_slot;
    logic [7:0] notify_length;
    logic [7:0] read_byte;
  } out_t;

endpackage

@@ rtl/urc_identifier_match_parser_core.sv @@
// Top level of the identifier match parser: sequencer, byte comparator,
// slot text and captured data RAMs. Depends on uimp_pkg and uimp_ram.
// Slot match and unregister walk the slot text RAM one byte per cycle through
// the shared byte comparator. Register writes staged_count+1 bytes, one per cycle.
// One item at a time. After reset a clearing pass zeroes the slot text.
module urc_identifier_match_parser_core
  import uimp_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDENT_MAX  = IDENT_MAX_DEF,
  parameter int DATA_MAX   = DATA_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int KW    = $clog2(IDENT_MAX);
  localparam int CNTW  = $clog2(IDENT_MAX + 1);
  localparam int CW    = $clog2(DATA_MAX + 1);
  localparam int DAW   = $clog2(DATA_MAX);
  localparam int TDEP  = SLOT_COUNT * IDENT_MAX;
  localparam int TAW   = $clog2(TDEP);

  typedef enum logic [1:0] {MODE_IDLE, MODE_IDENT, MODE_DATA, MODE_BAD} mode_t;
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MSLOT, S_MCMP, S_USLOT, S_UCMP, S_REG, S_RDWAIT, S_DONE
  } state_t;

  state_t          state_r;
  mode_t           mode_r;
  logic [7:0]      ident_r  [IDENT_MAX];
  logic [CNTW-1:0] ident_cnt_r;
  logic [7:0]      staged_r [IDENT_MAX];
  logic [CNTW-1:0] staged_cnt_r;
  logic [CNTW-1:0] slot_len_r [SLOT_COUNT];
  logic [CW-1:0]   cap_cnt_r;
  logic [SW-1:0]   active_slot_r;
  logic            unread_r;
  logic [SW-1:0]   slot_r;
  logic [TAW-1:0]  base_r;
  logic [KW-1:0]   k_r;
  logic [TAW-1:0]  clr_r;
  out_t            res_r;
  logic            out_valid_r;
  out_t            out_data_r;

  logic            accept;
  state_t          idle_nxt;
  logic            txt_we, txt_re;
  logic [TAW-1:0]  txt_waddr, txt_raddr;
  logic [7:0]      txt_wdata, txt_q;
  logic            dat_we, dat_re;
  logic [DAW-1:0]  dat_waddr, dat_raddr;
  logic [7:0]      dat_q;
  logic [7:0]      idx8;
  logic [7:0]      cmp_ref;
  logic [CNTW-1:0] cmp_len;
  logic            cmp_eq, cmp_last, slot_end;
  logic            empty_found;
  logic [SW-1:0]   empty_slot;
  logic [SW+2:0]   slot_ext;
  logic [CW+7:0]   cnt_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx8      = {1'b0, in_data.read_index};
  assign slot_ext  = {3'b000, active_slot_r};
  assign cnt_ext   = {8'h00, cap_cnt_r};
  assign slot_end  = (slot_r == SW'(SLOT_COUNT - 1));

  // first empty slot for register
  always_comb begin
    empty_found = 1'b0;
    empty_slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_len_r[i] == '0) begin
        empty_found = 1'b1;
        empty_slot  = SW'(i);
      end
    end
  end

  // sequencer step taken on a transfer
  always_comb begin
    idle_nxt = S_DONE;
    case (in_data.func)
      FN_MODEM: begin
        if ((mode_r == MODE_IDENT) && (in_data.data_byte == CH_END)) begin
          idle_nxt = S_MSLOT;
        end
      end
      FN_REG: begin
        if (empty_found) begin
          idle_nxt = S_REG;
        end
      end
      FN_UNREG: begin
        idle_nxt = S_USLOT;
      end
      FN_READ: begin
        if (unread_r && (idx8 < 8'(DATA_MAX))) begin
          idle_nxt = S_RDWAIT;
        end
      end
      default: begin
      end
    endcase
  end

  // shared byte comparator
  always_comb begin
    cmp_ref  = (state_r == S_MCMP) ? ident_r[k_r] : staged_r[k_r];
    cmp_len  = (state_r == S_MCMP) ? ident_cnt_r : staged_cnt_r;
    cmp_eq   = (txt_q == cmp_ref);
    cmp_last = ((CNTW'(k_r) + CNTW'(1)) == cmp_len);
  end

  always_comb begin
    txt_we    = 1'b0;
    txt_waddr = base_r + TAW'(k_r);
    txt_wdata = '0;
    txt_re    = 1'b0;
    txt_raddr = base_r;
    case (state_r)
      S_CLEAR: begin
        txt_we    = 1'b1;
        txt_waddr = clr_r;
      end
      S_REG: begin
        txt_we = 1'b1;
        if (CNTW'(k_r) < staged_cnt_r) begin
          txt_wdata = staged_r[k_r];
        end
      end
      S_MSLOT, S_USLOT: begin
        txt_re = 1'b1;
      end
      S_MCMP, S_UCMP: begin
        txt_re    = 1'b1;
        txt_raddr = base_r + TAW'(k_r) + TAW'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dat_we    = accept && (in_data.func == FN_MODEM) && (mode_r == MODE_DATA) &&
                (in_data.data_byte != CH_CR) && (cap_cnt_r < CW'(DATA_MAX));
    dat_waddr = cap_cnt_r[DAW-1:0];
    dat_re    = accept && (in_data.func == FN_READ);
    dat_raddr = idx8[DAW-1:0];
  end

  uimp_ram #(.WIDTH(8), .DEPTH(TDEP), .AW(TAW)) u_text_ram (
    .clk(clk), .we(txt_we), .waddr(txt_waddr), .wdata(txt_wdata),
    .re(txt_re), .raddr(txt_raddr), .rdata(txt_q)
  );

  uimp_ram #(.WIDTH(8), .DEPTH(DATA_MAX), .AW(DAW)) u_data_ram (
    .clk(clk), .we(dat_we), .waddr(dat_waddr), .wdata(in_data.data_byte),
    .re(dat_re), .raddr(dat_raddr), .rdata(dat_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      mode_r        <= MODE_IDLE;
      ident_cnt_r   <= '0;
      staged_cnt_r  <= '0;
      cap_cnt_r     <= '0;
      active_slot_r <= '0;
      unread_r      <= 1'b0;
      clr_r         <= '0;
      res_r         <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_len_r[i] <= '0;
      end
    end else begin
      if ((state_r == S_DONE) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + TAW'(1);
          if (clr_r == TAW'(TDEP - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= idle_nxt;
            case (in_data.func)
              FN_MODEM: begin
                case (mode_r)
                  MODE_IDLE: begin
                    if (in_data.data_byte == CH_START) begin
                      ident_cnt_r <= '0;
                      mode_r      <= MODE_IDENT;
                    end
                  end
                  MODE_IDENT: begin
                    if (in_data.data_byte == CH_END) begin
                      mode_r <= MODE_IDLE;
                      slot_r <= '0;
                      base_r <= '0;
                    end else if (ident_cnt_r >= CNTW'(IDENT_MAX)) begin
                      mode_r <= MODE_IDLE;
                    end else begin
                      ident_r[ident_cnt_r[KW-1:0]] <= in_data.data_byte;
                      ident_cnt_r <= ident_cnt_r + CNTW'(1);
                    end
                  end
                  MODE_DATA: begin
                    if (in_data.data_byte == CH_CR) begin
                      unread_r            <= 1'b1;
                      res_r.notify        <= 1'b1;
                      res_r.notify_slot   <= slot_ext[2:0];
                      res_r.notify_length <= cnt_ext[7:0];
                      mode_r              <= MODE_IDLE;
                    end else if (cap_cnt_r >= CW'(DATA_MAX)) begin
                      mode_r <= MODE_IDLE;
                    end else begin
                      cap_cnt_r <= cap_cnt_r + CW'(1);
                    end
                  end
                  default: begin
                    mode_r <= MODE_IDLE;
                  end
                endcase
              end
              FN_STAGE: begin
                if (staged_cnt_r >= CNTW'(IDENT_MAX - 1)) begin
                  res_r.status <= ST_STG_FULL;
                end else begin
                  staged_r[staged_cnt_r[KW-1:0]] <= in_data.data_byte;
                  staged_cnt_r <= staged_cnt_r + CNTW'(1);
                end
              end
              FN_REG: begin
                if (empty_found) begin
                  slot_r <= empty_slot;
                  base_r <= TAW'(TAW'(empty_slot) * TAW'(IDENT_MAX));
                  k_r    <= '0;
                end else begin
                  res_r.status <= ST_FULL;
                  staged_cnt_r <= '0;
                end
              end
              FN_UNREG: begin
                slot_r <= '0;
                base_r <= '0;
              end
              FN_READ: begin
                if (!unread_r || (idx8 >= 8'(DATA_MAX))) begin
                  res_r.status <= ST_NO_READ;
                end else if (in_data.last) begin
                  unread_r <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MSLOT: begin
          k_r <= '0;
          if (slot_len_r[slot_r] == ident_cnt_r) begin
            if (ident_cnt_r == '0) begin
              active_slot_r <= slot_r;
              cap_cnt_r     <= '0;
              mode_r        <= MODE_DATA;
              state_r       <= S_DONE;
            end else begin
              state_r <= S_MCMP;
            end
          end else if (slot_end) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + SW'(1);
            base_r <= base_r + TAW'(IDENT_MAX);
          end
        end
        S_USLOT: begin
          k_r <= '0;
          if (staged_cnt_r == '0) begin
            slot_len_r[slot_r] <= '0;
            state_r            <= S_DONE;
          end else begin
            state_r <= S_UCMP;
          end
        end
        S_MCMP, S_UCMP: begin
          if (cmp_eq && cmp_last) begin
            if (state_r == S_MCMP) begin
              active_slot_r <= slot_r;
              cap_cnt_r     <= '0;
              mode_r        <= MODE_DATA;
            end else begin
              slot_len_r[slot_r] <= '0;
              staged_cnt_r       <= '0;
            end
            state_r <= S_DONE;
          end else if (cmp_eq) begin
            k_r <= k_r + KW'(1);
          end else if (slot_end) begin
            if (state_r == S_UCMP) begin
              staged_cnt_r <= '0;
            end
            state_r <= S_DONE;
          end else begin
            slot_r  <= slot_r + SW'(1);
            base_r  <= base_r + TAW'(IDENT_MAX);
            state_r <= (state_r == S_MCMP) ? S_MSLOT : S_USLOT;
          end
        end
        S_REG: begin
          if (CNTW'(k_r) == staged_cnt_r) begin
            slot_len_r[slot_r] <= staged_cnt_r;
            staged_cnt_r       <= '0;
            state_r            <= S_DONE;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_RDWAIT: begin
          res_r.read_byte <= dat_q;
          state_r         <= S_DONE;
        end
        S_DONE: begin
          // hand the result over and clear it for the next item
          if (!out_valid_r || !out_stall) begin
            out_data_r <= res_r;
            res_r      <= '0;
            state_r    <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ident_cnt_r <= CNTW'(IDENT_MAX)) else $error("identifier count overrun");
  a_stage_bound: assert property (@(posedge clk) disable iff (!rst_n)
    staged_cnt_r <= CNTW'(IDENT_MAX - 1)) else $error("staging count overrun");
  a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cap_cnt_r <= CW'(DATA_MAX)) else $error("capture count overrun");
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall) else $error("transfer taken while busy");
  a_notify_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.notify) |-> (out_data_r.status == ST_OK))
    else $error("notify with error status");
`endif

endmodule

@@ rtl/uimp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uimp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
